FILE: src/fvpd_pkg.sv
package fvpd_pkg;

  // angle resolution used for the sine argument
  localparam int ANGLE_BITS = 12;
  localparam int DUTY_W     = 8;
  localparam logic [DUTY_W-1:0] DUTY_FULL = 8'd255;

  // register map (word index)
  localparam logic [1:0] REG_BUS_VOLTAGE = 2'd0;
  localparam logic [1:0] REG_POLE_PAIRS  = 2'd1;
  localparam logic [1:0] REG_DIRECTION   = 2'd2;
  localparam logic [1:0] REG_ZERO_OFFSET = 2'd3;

  localparam logic [15:0] BUS_RESET    = 16'd12000;
  localparam logic [5:0]  POLES_RESET  = 6'd7;
  localparam logic [11:0] OFFSET_RESET = 12'd0;

  // quarter-wave sine polynomial, Q30 coefficients
  localparam logic [31:0] SIN_C1 = 32'd1686629713;
  localparam logic [31:0] SIN_C3 = 32'd693598669;
  localparam logic [31:0] SIN_C5 = 32'd85569306;
  localparam logic [31:0] SIN_C7 = 32'd5026995;
  localparam logic [31:0] SIN_C9 = 32'd172272;

  // sqrt(3) * 2^15 / 4
  localparam logic [15:0] SQRT3_Q13 = 16'd14189;

  // widths of the phase math and the divider
  localparam int SUM_W = 50;
  localparam int T_W   = 46;
  localparam int NUM_W = T_W + DUTY_W;

  // pipeline layout
  localparam int SIN_STAGES = 7;
  localparam int DIV_STAGES = DUTY_W;
  localparam int NSTAGE     = 1 + SIN_STAGES + 4 + DIV_STAGES;
  localparam int ST_MUL1    = 1 + SIN_STAGES;

endpackage

FILE: src/foc_voltage_to_pwm_duty.sv
// Voltage-mode FOC output stage: quadrature voltage command to three PWM duties.
// Input channel (in_valid/in_ready): in_uq_mv, signed command in mV, and
// in_mech_angle, 12-bit mechanical angle. Result channel (out_valid/out_ready):
// out_duty_a/b/c, 8-bit duties, 255 = full on.
// Configuration through the APB port: bus voltage, pole pairs, direction and
// electrical zero offset; write only while no transaction is in flight.
// A transaction passes 20 register stages: one angle/clamp stage, seven sine
// polynomial stages, four multiply/sum stages and eight restoring divide
// stages, one quotient bit each. Throughput is one transaction per cycle while
// out_ready is high. Each stage carries its own valid bit, so a stalled
// receiver only holds the output stage; empty stages behind it keep filling
// and in_ready drops only when all 20 stages are occupied.
// Reset (rst_n low, synchronous) empties the pipeline and restores the
// registers to 12000 mV, 7 pole pairs, forward direction, zero offset.
// A bus voltage of zero yields all-zero duties.
module foc_voltage_to_pwm_duty import fvpd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_uq_mv,
  input  logic [11:0]        in_mech_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_duty_a,
  output logic [7:0]         out_duty_b,
  output logic [7:0]         out_duty_c,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // configuration registers
  logic [15:0] bus_r;
  logic [5:0]  poles_r;
  logic        dir_r;
  logic [11:0] zoff_r;
  logic [1:0]  reg_idx;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r   <= BUS_RESET;
      poles_r <= POLES_RESET;
      dir_r   <= 1'b0;
      zoff_r  <= OFFSET_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_BUS_VOLTAGE: bus_r   <= pwdata[15:0];
        REG_POLE_PAIRS:  poles_r <= pwdata[5:0];
        REG_DIRECTION:   dir_r   <= pwdata[0];
        REG_ZERO_OFFSET: zoff_r  <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BUS_VOLTAGE: prdata = {16'b0, bus_r};
      REG_POLE_PAIRS:  prdata = {26'b0, poles_r};
      REG_DIRECTION:   prdata = {31'b0, dir_r};
      REG_ZERO_OFFSET: prdata = {20'b0, zoff_r};
      default:         prdata = '0;
    endcase
  end

  // stage valids and per-stage advance (bubbles collapse)
  logic [NSTAGE-1:0] vld_r;
  logic [NSTAGE-1:0] en;

  always_comb begin
    en[NSTAGE-1] = !vld_r[NSTAGE-1] || out_ready;
    for (int i = NSTAGE-2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // stage 0: electrical angle, quadrant folding, command clamp
  logic [17:0] prod;
  logic [11:0] eang;
  logic [27:0] ewide;
  logic [ANGLE_BITS-1:0] ph_s, ph_c;
  logic [16:0] z_s, z_c;
  logic signed [17:0] uq2x, vbus;
  logic signed [16:0] uq2;

  always_comb begin
    prod  = 18'(poles_r) * 18'(in_mech_angle);
    eang  = dir_r ? (12'd0 - prod[11:0] - zoff_r) : (prod[11:0] - zoff_r);
    ewide = (28'(eang) << 4) >> (16 - ANGLE_BITS);
    ph_s  = ewide[ANGLE_BITS-1:0];
    ph_c  = ph_s + ANGLE_BITS'(1 << (ANGLE_BITS-2));
    z_s   = 17'(ph_s[ANGLE_BITS-3:0]) << (18 - ANGLE_BITS);
    z_c   = 17'(ph_c[ANGLE_BITS-3:0]) << (18 - ANGLE_BITS);
    if (ph_s[ANGLE_BITS-2]) z_s = 17'h10000 - z_s;
    if (ph_c[ANGLE_BITS-2]) z_c = 17'h10000 - z_c;
    uq2x = 18'(in_uq_mv) <<< 1;
    vbus = $signed({2'b0, bus_r});
    if (uq2x > vbus)       uq2x = vbus;
    else if (uq2x < -vbus) uq2x = -vbus;
    uq2 = uq2x[16:0];
  end

  logic [16:0] zs_r, zc_r;
  logic        ns_r, nc_r;
  logic signed [16:0] uq2_r [0:SIN_STAGES];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      zs_r     <= z_s;
      zc_r     <= z_c;
      ns_r     <= ph_s[ANGLE_BITS-1];
      nc_r     <= ph_c[ANGLE_BITS-1];
      uq2_r[0] <= uq2;
    end
  end

  // command travels alongside the sine pipeline
  for (genvar k = 1; k <= SIN_STAGES; k++) begin : g_uq
    always_ff @(posedge clk) begin
      if (en[k]) uq2_r[k] <= uq2_r[k-1];
    end
  end

  // stages 1..7: sine and cosine
  logic signed [15:0] sin_v, cos_v;

  fvpd_sine u_sin (
    .clk   (clk),
    .en    (en[SIN_STAGES:1]),
    .z_i   (zs_r),
    .neg_i (ns_r),
    .sin_o (sin_v)
  );

  fvpd_sine u_cos (
    .clk   (clk),
    .en    (en[SIN_STAGES:1]),
    .z_i   (zc_r),
    .neg_i (nc_r),
    .sin_o (cos_v)
  );

  // stage 8: uq*sin and cos*sqrt3
  logic signed [32:0] a1_r;
  logic signed [31:0] cb_r;
  logic signed [16:0] uqm_r;

  always_ff @(posedge clk) begin
    if (en[ST_MUL1]) begin
      a1_r  <= 33'(uq2_r[SIN_STAGES]) * 33'(sin_v);
      cb_r  <= 32'(cos_v) * $signed({16'b0, SQRT3_Q13});
      uqm_r <= uq2_r[SIN_STAGES];
    end
  end

  // stage 9: alpha and beta terms
  logic signed [SUM_W-1:0] alpha_r, beta_r;

  always_ff @(posedge clk) begin
    if (en[ST_MUL1+1]) begin
      alpha_r <= -(SUM_W'(a1_r) <<< 13);
      beta_r  <= SUM_W'(uqm_r) * SUM_W'(cb_r);
    end
  end

  // stage 10: inverse Clarke with half-bus offset, clamp to 0..full
  logic signed [SUM_W-1:0] offs, full, ta, tb, tc;
  logic [T_W-1:0] ca, cbv, cc;

  function automatic logic [T_W-1:0] clamp_t(logic signed [SUM_W-1:0] x,
                                             logic signed [SUM_W-1:0] f);
    logic signed [SUM_W-1:0] y;
    y = x;
    if (y < 0) y = '0;
    if (y > f) y = f;
    return y[T_W-1:0];
  endfunction

  always_comb begin
    offs = SUM_W'(bus_r) <<< 29;
    full = SUM_W'(bus_r) <<< 30;
    ta   = (alpha_r <<< 1) + offs;
    tb   = beta_r - alpha_r + offs;
    tc   = -alpha_r - beta_r + offs;
    ca   = clamp_t(ta, full);
    cbv  = clamp_t(tb, full);
    cc   = clamp_t(tc, full);
  end

  logic [T_W-1:0] ta_r, tb_r, tc_r;

  always_ff @(posedge clk) begin
    if (en[ST_MUL1+2]) begin
      ta_r <= ca;
      tb_r <= cbv;
      tc_r <= cc;
    end
  end

  // stage 11: numerator = DUTY_FULL * t
  logic [NUM_W-1:0] na_r, nb_r, nc2_r;

  always_ff @(posedge clk) begin
    if (en[ST_MUL1+3]) begin
      na_r  <= NUM_W'(ta_r) * NUM_W'(DUTY_FULL);
      nb_r  <= NUM_W'(tb_r) * NUM_W'(DUTY_FULL);
      nc2_r <= NUM_W'(tc_r) * NUM_W'(DUTY_FULL);
    end
  end

  // stages 12..19: divide by full scale
  logic [T_W-1:0] den;
  logic           nz;

  assign den = T_W'(bus_r) << 30;
  assign nz  = (bus_r != 16'd0);

  fvpd_div u_div_a (
    .clk (clk), .en (en[NSTAGE-1:ST_MUL1+4]),
    .num_i (na_r), .den_i (den), .nz_i (nz), .q_o (out_duty_a)
  );

  fvpd_div u_div_b (
    .clk (clk), .en (en[NSTAGE-1:ST_MUL1+4]),
    .num_i (nb_r), .den_i (den), .nz_i (nz), .q_o (out_duty_b)
  );

  fvpd_div u_div_c (
    .clk (clk), .en (en[NSTAGE-1:ST_MUL1+4]),
    .num_i (nc2_r), .den_i (den), .nz_i (nz), .q_o (out_duty_c)
  );

  // input stalls only with a full pipeline and a stalled receiver
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> ((&vld_r) && !out_ready))
    else $error("in_ready low with a free stage");

  // an accepted transaction occupies the first stage
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted transaction lost at entry");

  // output drains when nothing follows
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !vld_r[NSTAGE-2]) |=> !out_valid)
    else $error("result repeated after handshake");

endmodule

FILE: src/fvpd_sine.sv
module fvpd_sine import fvpd_pkg::*; (
  input  logic                  clk,
  input  logic [SIN_STAGES-1:0] en,
  input  logic [16:0]           z_i,
  input  logic                  neg_i,
  output logic signed [15:0]    sin_o
);

  logic [16:0] z_r   [0:4];
  logic [16:0] z2_r  [0:3];
  logic [31:0] t_r   [1:4];
  logic        neg_r [0:5];
  logic [31:0] s_r;
  logic signed [15:0] sin_r;

  logic [33:0] zz;
  logic [48:0] m1, m2, m3, m4, m5;
  logic [32:0] rsum;
  logic [17:0] rnd;
  logic [14:0] mag;

  // squared argument and Horner products
  always_comb begin
    zz   = 34'(z_i) * 34'(z_i);
    m1   = 49'(SIN_C9) * 49'(z2_r[0]);
    m2   = 49'(t_r[1]) * 49'(z2_r[1]);
    m3   = 49'(t_r[2]) * 49'(z2_r[2]);
    m4   = 49'(t_r[3]) * 49'(z2_r[3]);
    m5   = 49'(t_r[4]) * 49'(z_r[4]);
    rsum = 33'(s_r) + 33'd16384;
    rnd  = rsum[32:15];
    mag  = (rnd > 18'd32767) ? 15'h7fff : rnd[14:0];
  end

  // stage 0: z^2 >> 16
  always_ff @(posedge clk) begin
    if (en[0]) begin
      z_r[0]   <= z_i;
      z2_r[0]  <= zz[32:16];
      neg_r[0] <= neg_i;
    end
  end

  // stages 1..4: Horner steps
  always_ff @(posedge clk) begin
    if (en[1]) begin
      t_r[1] <= SIN_C7 - m1[47:16];
      z_r[1] <= z_r[0]; z2_r[1] <= z2_r[0]; neg_r[1] <= neg_r[0];
    end
    if (en[2]) begin
      t_r[2] <= SIN_C5 - m2[47:16];
      z_r[2] <= z_r[1]; z2_r[2] <= z2_r[1]; neg_r[2] <= neg_r[1];
    end
    if (en[3]) begin
      t_r[3] <= SIN_C3 - m3[47:16];
      z_r[3] <= z_r[2]; z2_r[3] <= z2_r[2]; neg_r[3] <= neg_r[2];
    end
    if (en[4]) begin
      t_r[4] <= SIN_C1 - m4[47:16];
      z_r[4] <= z_r[3]; neg_r[4] <= neg_r[3];
    end
  end

  // stage 5: final product, stage 6: round, saturate, sign
  always_ff @(posedge clk) begin
    if (en[5]) begin
      s_r      <= m5[47:16];
      neg_r[5] <= neg_r[4];
    end
    if (en[6]) begin
      sin_r <= neg_r[5] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  assign sin_o = sin_r;

endmodule

FILE: src/fvpd_div.sv
module fvpd_div import fvpd_pkg::*; (
  input  logic                  clk,
  input  logic [DIV_STAGES-1:0] en,
  input  logic [NUM_W-1:0]      num_i,
  input  logic [T_W-1:0]        den_i,
  input  logic                  nz_i,
  output logic [DUTY_W-1:0]     q_o
);

  logic [NUM_W-1:0]  rem_r [0:DIV_STAGES-1];
  logic [DUTY_W-1:0] q_r   [0:DIV_STAGES-1];

  // one restoring step/stage MSB first; user keeps divisor static if busy
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_step
    localparam int BIT = DIV_STAGES - 1 - j;
    logic [NUM_W-1:0]  rin, dk;
    logic [DUTY_W-1:0] qin;
    logic              take;

    if (j == 0) begin : g_first
      assign rin = num_i;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_r[j-1];
      assign qin = q_r[j-1];
    end

    assign dk   = NUM_W'(den_i) << BIT;
    assign take = nz_i && (rin >= dk);

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem_r[j] <= take ? rin - dk : rin;
        q_r[j]   <= qin | (take ? DUTY_W'(1) << BIT : '0);
      end
    end
  end

  assign q_o = q_r[DIV_STAGES-1];

endmodule
